@@ rtl/assert_macros.svh @@
// Assertion macros shared by the timer table RTL.
// No dependencies; included by every file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and active-low reset.
`define POTT_ASSERT_ON(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Concurrent assertion on the house clock and reset names.
`define POTT_ASSERT(label, prop, msg) \
	`POTT_ASSERT_ON(label, clk, arst_n, prop, msg)

`endif

@@ rtl/pott_pkg.sv @@
// Package for the periodic and one-shot timer table.
// Holds command and result codes, the command struct and shared constants.
package pott_pkg;

	localparam int TIMER_SLOTS_DEF   = 16;
	localparam int INTERVAL_BITS_DEF = 16;
	localparam int QUEUE_DEPTH       = 2;
	localparam int IN_INTERVAL_W     = 16;
	localparam int CALLBACK_W        = 8;
	localparam int CONTEXT_W         = 32;
	localparam int SECONDS_W         = 32;

	// Command classes produced by the front end.
	typedef enum logic [1:0] {
		OP_ADD,
		OP_REJ_ZERO,
		OP_TICK
	} op_t;

	// Result kinds as seen on the output channel.
	typedef enum logic [2:0] {
		KIND_ADDED     = 3'd0,
		KIND_REJ_ZERO  = 3'd1,
		KIND_REJ_FULL  = 3'd2,
		KIND_EXPIRY    = 3'd3,
		KIND_TICK_NONE = 3'd4
	} kind_t;

	// Sequencer states of the back end.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} back_state_t;

	// One classified command, less its interval.
	typedef struct packed {
		op_t                   op;
		logic                  one_shot;
		logic [CALLBACK_W-1:0] callback;
		logic [CONTEXT_W-1:0]  ctx;
	} cmd_t;

endpackage

@@ rtl/pott_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pott_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/pott_front.sv @@
// Front end of the timer table: takes input transfers and classifies them.
// Depends on pott_pkg.
module pott_front #(
	parameter int INTERVAL_BITS = 16
) (
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              func,
	input  logic [pott_pkg::IN_INTERVAL_W-1:0] interval_secs,
	input  logic                              one_shot,
	input  logic [pott_pkg::CALLBACK_W-1:0]   callback_id,
	input  logic [pott_pkg::CONTEXT_W-1:0]    context_word,
	input  logic                              q_full,
	output logic                              push,
	output pott_pkg::cmd_t                    cmd,
	output logic [INTERVAL_BITS-1:0]          ival
);
	import pott_pkg::*;

	logic [INTERVAL_BITS+IN_INTERVAL_W-1:0] ival_ext;

	// The interval is the low INTERVAL_BITS bits of the field, zero-extended.
	assign ival_ext = {{INTERVAL_BITS{1'b0}}, interval_secs};
	assign ival     = ival_ext[INTERVAL_BITS-1:0];

	// A transfer is taken whenever the queue has room.
	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	// Classify: ticks, adds with a zero interval, and ordinary adds.
	always_comb begin
		cmd.one_shot = one_shot;
		cmd.callback = callback_id;
		cmd.ctx      = context_word;
		if (func) begin
			cmd.op = OP_TICK;
		end else if (ival == '0) begin
			cmd.op = OP_REJ_ZERO;
		end else begin
			cmd.op = OP_ADD;
		end
	end

endmodule

@@ rtl/pott_queue.sv @@
// Short command queue between the front and back ends of the timer table.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module pott_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`POTT_ASSERT(a_queue_no_underflow, pop |-> not_empty, "queue popped while empty")
	`POTT_ASSERT(a_queue_bound, count_q <= CW'(DEPTH), "queue count beyond depth")

endmodule

@@ rtl/pott_back.sv @@
// Back end of the timer table: the table sequencer, slot RAM and result register.
// Depends on pott_pkg, pott_ram and assert_macros.svh.
`include "assert_macros.svh"
module pott_back #(
	parameter int TIMER_SLOTS   = 16,
	parameter int INTERVAL_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	input  pott_pkg::cmd_t                  q_cmd,
	input  logic [INTERVAL_BITS-1:0]        q_ival,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [2:0]                      kind,
	output logic [pott_pkg::CALLBACK_W-1:0] fired_callback,
	output logic [pott_pkg::CONTEXT_W-1:0]  fired_context,
	output logic [pott_pkg::SECONDS_W-1:0]  now_seconds,
	output logic                            last
);
	import pott_pkg::*;

	localparam int SW = $clog2(TIMER_SLOTS);
	localparam int NW = $clog2(TIMER_SLOTS + 1);

	typedef struct packed {
		logic                     one_shot;
		logic [INTERVAL_BITS-1:0] period;
		logic [INTERVAL_BITS-1:0] remaining;
		logic [CALLBACK_W-1:0]    callback;
		logic [CONTEXT_W-1:0]     ctx;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	back_state_t           state_q, state_d;
	logic [NW-1:0]         used_q;
	logic [NW-1:0]         i_q;
	logic [NW-1:0]         w_q;
	logic [NW-1:0]         i_next;
	logic [SECONDS_W-1:0]  seconds_q;
	logic                  pend_valid_q;
	logic [CALLBACK_W-1:0] pend_cb_q;
	logic [CONTEXT_W-1:0]  pend_ctx_q;

	logic                  out_valid_q;
	kind_t                 kind_q;
	logic [CALLBACK_W-1:0] cb_q;
	logic [CONTEXT_W-1:0]  ctx_q;
	logic [SECONDS_W-1:0]  now_q;
	logic                  last_q;

	logic                     ram_we, ram_re;
	logic [SW-1:0]            ram_waddr, ram_raddr;
	slot_t                    ram_wslot, rd_slot;
	logic [SLOT_W-1:0]        ram_rdata;
	logic [INTERVAL_BITS-1:0] rem_dec;
	logic                     hit, keep, advance, more, out_free, table_full;

	logic                  out_load;
	kind_t                 kind_d;
	logic [CALLBACK_W-1:0] cb_d;
	logic [CONTEXT_W-1:0]  ctx_d;
	logic                  last_d;

	pott_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (TIMER_SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wslot),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Slot under scan and its decremented count.
	assign rd_slot    = slot_t'(ram_rdata);
	assign rem_dec    = rd_slot.remaining - 1'b1;
	assign hit        = (rem_dec == '0);
	assign keep       = !(hit && rd_slot.one_shot);
	assign i_next     = i_q + 1'b1;
	assign more       = (i_next < used_q);
	assign out_free   = !out_valid_q || out_ready;
	assign table_full = (used_q == NW'(TIMER_SLOTS));
	// A new expiry must push the pending one out first, which needs the result register.
	assign advance    = !hit || !pend_valid_q || out_free;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && q_cmd.op == OP_TICK) begin
					state_d = (used_q == '0) ? ST_FLUSH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (advance && !more) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: queue pop, RAM ports and result load.
	always_comb begin
		pop       = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = w_q[SW-1:0];
		ram_wslot = rd_slot;
		ram_re    = 1'b0;
		ram_raddr = i_next[SW-1:0];
		out_load  = 1'b0;
		kind_d    = KIND_ADDED;
		cb_d      = '0;
		ctx_d     = '0;
		last_d    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_cmd.op)
						OP_TICK: begin
							pop       = 1'b1;
							ram_re    = (used_q != '0);
							ram_raddr = '0;
						end
						OP_ADD: begin
							if (out_free) begin
								pop       = 1'b1;
								out_load  = 1'b1;
								kind_d    = table_full ? KIND_REJ_FULL : KIND_ADDED;
								ram_we    = !table_full;
								ram_waddr = used_q[SW-1:0];
								ram_wslot.one_shot  = q_cmd.one_shot;
								ram_wslot.period    = q_ival;
								ram_wslot.remaining = q_ival;
								ram_wslot.callback  = q_cmd.callback;
								ram_wslot.ctx       = q_cmd.ctx;
							end
						end
						OP_REJ_ZERO: begin
							if (out_free) begin
								pop      = 1'b1;
								out_load = 1'b1;
								kind_d   = KIND_REJ_ZERO;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (advance) begin
					// The pending expiry is not the last one: send it on.
					if (hit && pend_valid_q) begin
						out_load = 1'b1;
						kind_d   = KIND_EXPIRY;
						cb_d     = pend_cb_q;
						ctx_d    = pend_ctx_q;
						last_d   = 1'b0;
					end
					ram_we              = keep;
					ram_wslot.remaining = hit ? rd_slot.period : rem_dec;
					ram_re              = more;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					out_load = 1'b1;
					if (pend_valid_q) begin
						kind_d = KIND_EXPIRY;
						cb_d   = pend_cb_q;
						ctx_d  = pend_ctx_q;
					end else begin
						kind_d = KIND_TICK_NONE;
					end
				end
			end
			default: ;
		endcase
	end

	// Sequencer registers, table fill and seconds count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			used_q       <= '0;
			i_q          <= '0;
			w_q          <= '0;
			seconds_q    <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (q_valid && q_cmd.op == OP_TICK) begin
						seconds_q <= seconds_q + 1'b1;
						i_q       <= '0;
						w_q       <= '0;
					end else if (pop && q_cmd.op == OP_ADD && !table_full) begin
						used_q <= used_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (advance) begin
						i_q <= i_next;
						if (keep) begin
							w_q <= w_q + 1'b1;
						end
						if (hit) begin
							pend_valid_q <= 1'b1;
						end
						if (!more) begin
							used_q <= keep ? w_q + 1'b1 : w_q;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						pend_valid_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Pending expiry payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && advance && hit) begin
			pend_cb_q  <= rd_slot.callback;
			pend_ctx_q <= rd_slot.ctx;
		end
	end

	// Result register: holds a result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q <= kind_d;
			cb_q   <= cb_d;
			ctx_q  <= ctx_d;
			now_q  <= seconds_q;
			last_q <= last_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign fired_callback = cb_q;
	assign fired_context  = ctx_q;
	assign now_seconds    = now_q;
	assign last           = last_q;

	`POTT_ASSERT(a_idle_no_pend, state_q == ST_IDLE |-> !pend_valid_q, "pending expiry in idle")
	`POTT_ASSERT(a_back_used_bound, used_q <= NW'(TIMER_SLOTS), "table fill beyond slot count")
	`POTT_ASSERT(a_scan_order, state_q == ST_SCAN |-> w_q <= i_q && i_q < used_q, "bad scan index")

endmodule

@@ rtl/periodic_oneshot_timer_table_top.sv @@
// Top level of the periodic and one-shot timer table.
// Depends on pott_pkg, pott_front, pott_queue and pott_back.
//
// Input channel (in_valid/in_ready): func 0 adds a timer with interval_secs,
// one_shot, callback_id and context_word; func 1 is a one-second tick.
// Output channel (out_valid/out_ready): one result per add, and per tick one
// expiry result for each timer that reaches zero, in table order, or a single
// status result when none does; last marks the final result of an input.
// A two-entry command queue parts the input side from the table sequencer,
// so inputs keep being taken while results wait, as long as the queue has room.
// An add passes through the command queue and then the result register. A tick
// starts, then visits each valid slot (the slot RAM is read and written back one
// slot per cycle while no result is stalled), and then closes; the receiver can
// also stall a result.
// When out_ready is low the sequencer pauses at the next result it must hand
// over; the result register holds it unchanged until its transfer.
// Reset empties the table and the queue and clears the seconds count; no
// clearing pass is needed, the fill count marks which slots are live.
module periodic_oneshot_timer_table_top #(
	parameter int TIMER_SLOTS   = pott_pkg::TIMER_SLOTS_DEF,
	parameter int INTERVAL_BITS = pott_pkg::INTERVAL_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               func,
	input  logic [pott_pkg::IN_INTERVAL_W-1:0] interval_secs,
	input  logic                               one_shot,
	input  logic [pott_pkg::CALLBACK_W-1:0]    callback_id,
	input  logic [pott_pkg::CONTEXT_W-1:0]     context_word,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [2:0]                         kind,
	output logic [pott_pkg::CALLBACK_W-1:0]    fired_callback,
	output logic [pott_pkg::CONTEXT_W-1:0]     fired_context,
	output logic [pott_pkg::SECONDS_W-1:0]     now_seconds,
	output logic                               last
);
	import pott_pkg::*;

	localparam int QW = $bits(cmd_t) + INTERVAL_BITS;

	logic                     q_full, q_push, q_pop, q_valid;
	cmd_t                     f_cmd, q_cmd;
	logic [INTERVAL_BITS-1:0] f_ival, q_ival;
	logic [QW-1:0]            q_rd_data;

	pott_front #(
		.INTERVAL_BITS (INTERVAL_BITS)
	) u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.interval_secs (interval_secs),
		.one_shot      (one_shot),
		.callback_id   (callback_id),
		.context_word  (context_word),
		.q_full        (q_full),
		.push          (q_push),
		.cmd           (f_cmd),
		.ival          (f_ival)
	);

	pott_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_data   ({f_cmd, f_ival}),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.rd_data   (q_rd_data)
	);

	// Split the queue head back into command and interval.
	assign {q_cmd, q_ival} = q_rd_data;

	pott_back #(
		.TIMER_SLOTS   (TIMER_SLOTS),
		.INTERVAL_BITS (INTERVAL_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_cmd          (q_cmd),
		.q_ival         (q_ival),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.fired_callback (fired_callback),
		.fired_context  (fired_context),
		.now_seconds    (now_seconds),
		.last           (last)
	);

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for periodic_oneshot_timer_table_top.
// Depends on pott_pkg and the timer table RTL; a directed table, then random
// add and tick traffic with bursty transfers, all checked against a predictor.
`timescale 1ns / 1ps

module tb;
	import pott_pkg::*;

	localparam int SLOTS       = TIMER_SLOTS_DEF;
	localparam int IVAL_W      = INTERVAL_BITS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 3 * SLOTS + 16;

	// Input function codes.
	localparam logic FUNC_ADD  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef struct packed {
		logic                  func;
		logic [IN_INTERVAL_W-1:0] interval;
		logic                  one_shot;
		logic [CALLBACK_W-1:0] callback;
		logic [CONTEXT_W-1:0]  ctx;
	} timer_cmd_t;

	typedef struct packed {
		kind_t                 kind;
		logic [CALLBACK_W-1:0] callback;
		logic [CONTEXT_W-1:0]  ctx;
		logic [SECONDS_W-1:0]  now;
		logic                  last;
	} timer_result_t;

	typedef struct packed {
		timer_cmd_t           cmd;
		logic                 typed;
		kind_t                typed_kind;
		logic [SECONDS_W-1:0] typed_now;
	} stim_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic                     func;
	logic [IN_INTERVAL_W-1:0] interval_secs;
	logic                     one_shot;
	logic [CALLBACK_W-1:0]    callback_id;
	logic [CONTEXT_W-1:0]     context_word;
	logic                     out_valid;
	logic                     out_ready;
	logic [2:0]               kind;
	logic [CALLBACK_W-1:0]    fired_callback;
	logic [CONTEXT_W-1:0]     fired_context;
	logic [SECONDS_W-1:0]     now_seconds;
	logic                     last;

	// Predicted table contents, kept packed at the front as in the block.
	logic                  slot_live     [SLOTS];
	logic                  slot_single   [SLOTS];
	logic [IVAL_W-1:0]     slot_period   [SLOTS];
	logic [IVAL_W-1:0]     slot_left     [SLOTS];
	logic [CALLBACK_W-1:0] slot_cb       [SLOTS];
	logic [CONTEXT_W-1:0]  slot_ctx      [SLOTS];
	logic [SECONDS_W-1:0]  clock_secs;

	timer_result_t step_results[$];
	timer_result_t awaited_results[$];
	stim_row_t     stimulus_rows[$];
	timer_result_t seen;
	int            mismatch_count;
	int            cycle_count;

	periodic_oneshot_timer_table_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.interval_secs  (interval_secs),
		.one_shot       (one_shot),
		.callback_id    (callback_id),
		.context_word   (context_word),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.fired_callback (fired_callback),
		.fired_context  (fired_context),
		.now_seconds    (now_seconds),
		.last           (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Works out the results of one input and updates the predicted table.
	task automatic predict_timer_step(input timer_cmd_t cmd);
		logic [IVAL_W-1:0] ival;
		timer_result_t     res;
		int                used;
		int                keep;
		int                i;
		step_results.delete();
		res.callback = '0;
		res.ctx      = '0;
		res.last     = 1'b1;
		if (cmd.func == FUNC_ADD) begin
			ival = cmd.interval[IVAL_W-1:0];
			used = 0;
			while (used < SLOTS && slot_live[used])
				used++;
			res.now = clock_secs;
			if (ival == '0) begin
				res.kind = KIND_REJ_ZERO;
			end else if (used >= SLOTS) begin
				res.kind = KIND_REJ_FULL;
			end else begin
				res.kind            = KIND_ADDED;
				slot_live[used]     = 1'b1;
				slot_single[used]   = cmd.one_shot;
				slot_period[used]   = ival;
				slot_left[used]     = ival;
				slot_cb[used]       = cmd.callback;
				slot_ctx[used]      = cmd.ctx;
			end
			step_results.push_back(res);
		end else begin
			clock_secs = clock_secs + 1;
			res.now    = clock_secs;
			keep       = 0;
			for (i = 0; i < SLOTS; i++) begin
				if (slot_live[i]) begin
					slot_left[i] = slot_left[i] - 1'b1;
					if (slot_left[i] == '0) begin
						res.kind     = KIND_EXPIRY;
						res.callback = slot_cb[i];
						res.ctx      = slot_ctx[i];
						res.last     = 1'b0;
						step_results.push_back(res);
						if (slot_single[i])
							slot_live[i] = 1'b0;
						else
							slot_left[i] = slot_period[i];
					end
					// Survivors slide down over removed one-shot timers.
					if (slot_live[i]) begin
						if (keep != i) begin
							slot_live[keep]   = 1'b1;
							slot_single[keep] = slot_single[i];
							slot_period[keep] = slot_period[i];
							slot_left[keep]   = slot_left[i];
							slot_cb[keep]     = slot_cb[i];
							slot_ctx[keep]    = slot_ctx[i];
						end
						keep++;
					end
				end
			end
			for (i = keep; i < SLOTS; i++)
				slot_live[i] = 1'b0;
			if (step_results.size() == 0) begin
				res.kind     = KIND_TICK_NONE;
				res.callback = '0;
				res.ctx      = '0;
				res.last     = 1'b1;
			end else begin
				res      = step_results.pop_back();
				res.last = 1'b1;
			end
			step_results.push_back(res);
		end
	endtask

	task automatic put_row(input logic f, input logic [IN_INTERVAL_W-1:0] ival,
			input logic single, input logic [CALLBACK_W-1:0] cb,
			input logic [CONTEXT_W-1:0] ctx, input logic typed,
			input kind_t want_kind, input logic [SECONDS_W-1:0] want_now);
		stim_row_t row;
		row.cmd.func      = f;
		row.cmd.interval  = ival;
		row.cmd.one_shot  = single;
		row.cmd.callback  = cb;
		row.cmd.ctx       = ctx;
		row.typed         = typed;
		row.typed_kind    = want_kind;
		row.typed_now     = want_now;
		stimulus_rows.push_back(row);
	endtask

	// Random rows: mostly short intervals so that timers fire, with some
	// zero intervals and some full-range ones.
	task automatic queue_random_rows(input int count, input int add_pct);
		int                       k;
		int                       pick;
		logic [IN_INTERVAL_W-1:0] ival;
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				ival = '0;
			else if (pick < 18)
				ival = IN_INTERVAL_W'($urandom_range(0, 65535));
			else
				ival = IN_INTERVAL_W'($urandom_range(1, 4));
			put_row(($urandom_range(0, 99) < add_pct) ? FUNC_ADD : FUNC_TICK, ival,
				1'($urandom_range(0, 1)), CALLBACK_W'($urandom_range(0, 255)),
				$urandom, 1'b0, KIND_ADDED, '0);
		end
	endtask

	// Sends the queued rows in bursts of random length with random gaps.
	// Called and returning at a falling edge.
	task automatic play_rows();
		stim_row_t     row;
		timer_result_t res;
		int            burst_left;
		int            gap;
		burst_left = $urandom_range(1, 8);
		while (stimulus_rows.size() > 0) begin
			row           = stimulus_rows.pop_front();
			in_valid      <= 1'b1;
			func          <= row.cmd.func;
			interval_secs <= row.cmd.interval;
			one_shot      <= row.cmd.one_shot;
			callback_id   <= row.cmd.callback;
			context_word  <= row.cmd.ctx;
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			// The transfer has happened: record what it must produce.
			predict_timer_step(row.cmd);
			if (row.typed) begin
				res.kind     = row.typed_kind;
				res.callback = '0;
				res.ctx      = '0;
				res.now      = row.typed_now;
				res.last     = 1'b1;
				awaited_results.push_back(res);
			end else begin
				foreach (step_results[j])
					awaited_results.push_back(step_results[j]);
			end
			@(negedge clk);
			burst_left--;
			if (burst_left == 0) begin
				gap = $urandom_range(0, 5);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				burst_left = $urandom_range(1, 8);
			end
		end
		in_valid <= 1'b0;
	endtask

	task automatic wait_for_drain();
		while (awaited_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Receiver: stretches of full rate, random stalls, a regular pattern and
	// long holds.
	initial begin
		int mode;
		int len;
		int k;
		out_ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			len  = $urandom_range(4, 40);
			for (k = 0; k < len; k++) begin
				@(negedge clk);
				case (mode)
					0: begin
						out_ready <= 1'b1;
					end
					1: begin
						out_ready <= 1'($urandom_range(0, 1));
					end
					2: begin
						out_ready <= (k % 4) != 0;
					end
					default: begin
						out_ready <= (k >= 12);
					end
				endcase
			end
		end
	end

	// Each result transfer is compared with the oldest awaited result.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result, kind %0d callback %0h context %0h now %0h",
					$time, kind, fired_callback, fired_context, now_seconds);
				mismatch_count++;
			end else begin
				seen = awaited_results.pop_front();
				check_field("kind", 32'(seen.kind), 32'(kind));
				check_field("fired_callback", 32'(seen.callback), 32'(fired_callback));
				check_field("fired_context", seen.ctx, fired_context);
				check_field("now_seconds", seen.now, now_seconds);
				check_field("last", 32'(seen.last), 32'(last));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		int k;
		mismatch_count = 0;
		cycle_count    = 0;
		clock_secs     = '0;
		for (k = 0; k < SLOTS; k++)
			slot_live[k] = 1'b0;
		in_valid      = 1'b0;
		func          = FUNC_ADD;
		interval_secs = '0;
		one_shot      = 1'b0;
		callback_id   = '0;
		context_word  = '0;
		arst_n        = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table: empty tick, zero interval, extreme fields, a full
		// table, zero interval on a full table, then ticks with many expiries.
		put_row(FUNC_TICK, '0, 1'b0, 8'h00, 32'h0, 1'b1, KIND_TICK_NONE, 32'd1);
		put_row(FUNC_ADD, '0, 1'b1, 8'h11, 32'h1, 1'b1, KIND_REJ_ZERO, 32'd1);
		put_row(FUNC_ADD, 16'd1, 1'b0, 8'hFF, 32'hFFFF_FFFF, 1'b1, KIND_ADDED, 32'd1);
		put_row(FUNC_ADD, 16'd1, 1'b1, 8'h00, 32'h0, 1'b1, KIND_ADDED, 32'd1);
		put_row(FUNC_ADD, 16'hFFFF, 1'b0, 8'hA5, 32'h5A5A_A5A5, 1'b1, KIND_ADDED, 32'd1);
		put_row(FUNC_ADD, 16'd2, 1'b1, 8'h3C, 32'h8000_0001, 1'b1, KIND_ADDED, 32'd1);
		for (k = 0; k < SLOTS - 4; k++)
			put_row(FUNC_ADD, 16'd1, 1'(k), CALLBACK_W'(k * 17 + 1),
				{8'(k), 24'hC0FFEE}, 1'b1, KIND_ADDED, 32'd1);
		put_row(FUNC_ADD, 16'd3, 1'b0, 8'h77, 32'h7, 1'b1, KIND_REJ_FULL, 32'd1);
		put_row(FUNC_ADD, '0, 1'b0, 8'h00, 32'h0, 1'b1, KIND_REJ_ZERO, 32'd1);
		put_row(FUNC_TICK, 16'hFFFF, 1'b1, 8'hFF, 32'hFFFF_FFFF, 1'b0, KIND_ADDED, '0);
		put_row(FUNC_TICK, '0, 1'b0, 8'h00, 32'h0, 1'b0, KIND_ADDED, '0);
		put_row(FUNC_ADD, 16'h8000, 1'b1, 8'h5A, 32'h0000_FFFF, 1'b1, KIND_ADDED, 32'd3);
		put_row(FUNC_TICK, '0, 1'b0, 8'h00, 32'h0, 1'b0, KIND_ADDED, '0);
		play_rows();
		// The sender holds off until every awaited result has arrived.
		wait_for_drain();

		// Add-heavy traffic fills the table, tick-heavy traffic drains it.
		queue_random_rows(42, 55);
		play_rows();
		wait_for_drain();
		queue_random_rows(34, 30);
		play_rows();

		wait_for_drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
